/* rtl/wftl_pkg.sv */
// ----------------------------------------------------------------------------
// Wildcard flow table lookup: shared types and codes
// Beat layouts, entry layout, chain carry and broadcast control for the
// flow table cells.
// ----------------------------------------------------------------------------
`default_nettype none

package wftl_pkg;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN  = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  handle;
      logic [7:0]  proto;
      logic [15:0] sport;
      logic [31:0] sip;
      logic [15:0] dport;
      logic [31:0] dip;
      logic [2:0]  max_score;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] found_handle;
      logic [2:0] found_score;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  proto;
      logic [15:0] sport;
      logic [31:0] sip;
      logic [15:0] dport;
      logic [31:0] dip;
   } entry_type;

   typedef struct packed {
      logic       found;
      logic       done;
      logic       have;
      logic [2:0] best;
      logic [7:0] pick;
   } carry_type;

   typedef struct packed {
      logic insert;
      logic launch;
      logic shift;
      logic is_remove;
   } ctrl_type;

endpackage

`default_nettype wire

/* rtl/wftl_cell.sv */
// ----------------------------------------------------------------------------
// Flow table cell
// Holds one table entry, scores it against the broadcast key as the scan
// wave passes, and takes its neighbour's entry when the table closes a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module wftl_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  wftl_pkg::ctrl_type   ctrl,
   input  wftl_pkg::req_type    key,
   input  wire                  prev_valid,
   input  wire                  next_valid,
   input  wftl_pkg::entry_type  next_entry,
   input  wire                  wave_in,
   input  wftl_pkg::carry_type  carry_in,
   output logic                 valid_out,
   output wftl_pkg::entry_type  entry_out,
   output logic                 wave_out,
   output wftl_pkg::carry_type  carry_out
);

   logic                valid_ff, valid_in;
   wftl_pkg::entry_type entry_ff, entry_in;
   logic                wave_ff;
   wftl_pkg::carry_type carry_ff, carry_in_next;
   logic                shift_ff, shift_in;

   logic       sp_ok, sa_ok, dp_ok, da_ok, hit;
   logic [2:0] score;

   always_comb begin
      sp_ok = (entry_ff.sport == 16'd0) || (entry_ff.sport == key.sport);
      sa_ok = (entry_ff.sip == 32'd0) || (entry_ff.sip == key.sip);
      dp_ok = (entry_ff.dport == 16'd0) || (entry_ff.dport == key.dport);
      da_ok = (entry_ff.dip == 32'd0) || (entry_ff.dip == key.dip);
      hit   = valid_ff && (entry_ff.proto == key.proto) && sp_ok && sa_ok && dp_ok && da_ok;
      score = {2'b00, entry_ff.sport != 16'd0} + {2'b00, entry_ff.sip != 32'd0}
            + {2'b00, entry_ff.dport != 16'd0} + {2'b00, entry_ff.dip != 32'd0};
   end

   always_comb begin
      carry_in_next = carry_in;
      if (ctrl.is_remove) begin
         if (!carry_in.found && valid_ff && (entry_ff.id == key.handle)) begin
            carry_in_next.found = 1'b1;
         end
      end else if (!carry_in.done && hit) begin
         if (score == key.max_score) begin
            carry_in_next.done = 1'b1;
            carry_in_next.have = 1'b1;
            carry_in_next.best = score;
            carry_in_next.pick = entry_ff.id;
         end else if (score > carry_in.best) begin
            carry_in_next.have = 1'b1;
            carry_in_next.best = score;
            carry_in_next.pick = entry_ff.id;
         end
      end
   end

   always_comb begin
      shift_in = shift_ff;
      if (wave_in && ctrl.is_remove) begin
         shift_in = carry_in_next.found;
      end else if (ctrl.launch) begin
         shift_in = 1'b0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ctrl.shift && shift_ff) begin
         valid_in = next_valid;
         entry_in = next_entry;
      end else if (ctrl.insert && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         entry_in = '{id: key.handle, proto: key.proto, sport: key.sport,
                      sip: key.sip, dport: key.dport, dip: key.dip};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         wave_ff  <= 1'b0;
         shift_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         wave_ff  <= wave_in;
         shift_ff <= shift_in;
      end
      entry_ff <= entry_in;
      carry_ff <= carry_in_next;
   end

   assign valid_out = valid_ff;
   assign entry_out = entry_ff;
   assign wave_out  = wave_ff;
   assign carry_out = carry_ff;

endmodule

`default_nettype wire

/* rtl/wildcard_flow_table_lookup.sv */
// ----------------------------------------------------------------------------
// Wildcard flow table lookup
// Insertion-ordered table of wildcard flow entries held in a chain of cells,
// with insert, remove by handle and best-match lookup.
// ----------------------------------------------------------------------------
// Insert and unused kinds: the result beat is registered in ST_EXEC.
// Lookup and remove: a scan wave crosses one cell per cycle, and the result
// beat is registered as the wave leaves the last cell; busy stays high until
// then. One beat is taken at a time; the result strobe lasts one cycle and the
// receiver cannot hold it off. Synchronous reset empties the table at once.
`default_nettype none

module wildcard_flow_table_lookup #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wftl_pkg::req_type  req_item,
   output logic               rsp_strobe,
   output wftl_pkg::rsp_type  rsp_item
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_WAVE = 2'd2;

   logic [1:0]         state_ff, state_in;
   wftl_pkg::req_type  req_ff, req_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   wftl_pkg::rsp_type  rsp_ff, rsp_in;
   wftl_pkg::ctrl_type ctrl;

   logic                valid_link [0:TABLE_DEPTH+1];
   wftl_pkg::entry_type entry_link [1:TABLE_DEPTH+1];
   logic                wave_link  [0:TABLE_DEPTH];
   wftl_pkg::carry_type carry_link [0:TABLE_DEPTH];

   assign valid_link[0]             = 1'b1;
   assign valid_link[TABLE_DEPTH+1] = 1'b0;
   assign entry_link[TABLE_DEPTH+1] = '0;
   assign wave_link[0]              = ctrl.launch;
   assign carry_link[0]             = '0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      wftl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .key        (req_ff),
         .prev_valid (valid_link[i]),
         .next_valid (valid_link[i+2]),
         .next_entry (entry_link[i+2]),
         .wave_in    (wave_link[i]),
         .carry_in   (carry_link[i]),
         .valid_out  (valid_link[i+1]),
         .entry_out  (entry_link[i+1]),
         .wave_out   (wave_link[i+1]),
         .carry_out  (carry_link[i+1])
      );
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ctrl          = '0;
      ctrl.is_remove = (req_ff.kind == wftl_pkg::KIND_REMOVE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_in = '{status: wftl_pkg::STATUS_NO_MATCH, found_handle: 8'd0,
                       found_score: 3'd0};
            unique case (req_ff.kind) inside
               wftl_pkg::KIND_INSERT: begin
                  ctrl.insert   = 1'b1;
                  rsp_in.status = valid_link[TABLE_DEPTH] ? wftl_pkg::STATUS_FULL
                                                          : wftl_pkg::STATUS_OK;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
               wftl_pkg::KIND_REMOVE, wftl_pkg::KIND_LOOKUP: begin
                  ctrl.launch = 1'b1;
                  state_in    = ST_WAVE;
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
            endcase
         end
         ST_WAVE: begin
            if (wave_link[TABLE_DEPTH]) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
               if (ctrl.is_remove) begin
                  ctrl.shift = carry_link[TABLE_DEPTH].found;
                  rsp_in.status = carry_link[TABLE_DEPTH].found ? wftl_pkg::STATUS_OK
                                                                : wftl_pkg::STATUS_UNKNOWN;
               end else if (carry_link[TABLE_DEPTH].have) begin
                  rsp_in.status       = wftl_pkg::STATUS_OK;
                  rsp_in.found_handle = carry_link[TABLE_DEPTH].pick;
                  rsp_in.found_score  = carry_link[TABLE_DEPTH].best;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

/* tb/wildcard_flow_table_lookup_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard flow table lookup testbench
// A short table of directed beats, then about a thousand random insert,
// remove, lookup and unused-kind beats, sent in bursts. Every result beat is
// compared with a typed answer or that of a flow table beside the block.
// ----------------------------------------------------------------------------

module wildcard_flow_table_lookup_tb;

   localparam int TABLE_DEPTH   = 32;
   localparam int RANDOM_BEATS  = 1000;
   localparam int DIRECTED_ROWS = 23;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = TABLE_DEPTH + 4;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      wftl_pkg::req_type beat;
      bit                typed;
      wftl_pkg::rsp_type answer;
   } directed_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   wftl_pkg::req_type req_item;
   logic              rsp_strobe;
   wftl_pkg::rsp_type rsp_item;

   wftl_pkg::entry_type flow_entries [TABLE_DEPTH];
   int                  flow_count = 0;
   int                  peak_count = 0;
   wftl_pkg::rsp_type   expected_answers [$];
   directed_row_type    directed_rows [DIRECTED_ROWS];
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  burst_left = 0;
   int                  insert_bias = 50;
   int                  kind_tally [4] = '{0, 0, 0, 0};
   int                  status_tally [4] = '{0, 0, 0, 0};

   wildcard_flow_table_lookup #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic wftl_pkg::req_type make_beat(logic [1:0] kind, logic [7:0] handle,
                                                   logic [7:0] proto, logic [15:0] sport,
                                                   logic [31:0] sip, logic [15:0] dport,
                                                   logic [31:0] dip, logic [2:0] max_score);
      return '{kind, handle, proto, sport, sip, dport, dip, max_score};
   endfunction

   function automatic wftl_pkg::rsp_type answer(logic [1:0] status, logic [7:0] found_handle,
                                                logic [2:0] found_score);
      return '{status, found_handle, found_score};
   endfunction

   function automatic int entry_score(wftl_pkg::entry_type e, wftl_pkg::req_type b);
      int score;
      score = 0;
      if (e.proto != b.proto) return -1;
      if (e.sport != '0) begin
         if (e.sport != b.sport) return -1;
         score++;
      end
      if (e.sip != '0) begin
         if (e.sip != b.sip) return -1;
         score++;
      end
      if (e.dport != '0) begin
         if (e.dport != b.dport) return -1;
         score++;
      end
      if (e.dip != '0) begin
         if (e.dip != b.dip) return -1;
         score++;
      end
      return score;
   endfunction

   function automatic wftl_pkg::rsp_type flow_table_apply(wftl_pkg::req_type b);
      wftl_pkg::rsp_type r;
      int      score;
      int      best;
      int      pick;
      bit      settled;
      r = answer(wftl_pkg::STATUS_NO_MATCH, 8'h00, 3'd0);
      case (b.kind)
         wftl_pkg::KIND_INSERT: begin
            if (flow_count >= TABLE_DEPTH) begin
               r.status = wftl_pkg::STATUS_FULL;
            end else begin
               flow_entries[flow_count] = '{b.handle, b.proto, b.sport, b.sip,
                                            b.dport, b.dip};
               flow_count++;
               r.status = wftl_pkg::STATUS_OK;
            end
         end
         wftl_pkg::KIND_REMOVE: begin
            pick = -1;
            for (int i = 0; i < flow_count; i++) begin
               if (pick < 0 && flow_entries[i].id == b.handle) pick = i;
            end
            if (pick < 0) begin
               r.status = wftl_pkg::STATUS_UNKNOWN;
            end else begin
               for (int i = pick; i < flow_count - 1; i++) flow_entries[i] = flow_entries[i + 1];
               flow_count--;
               r.status = wftl_pkg::STATUS_OK;
            end
         end
         wftl_pkg::KIND_LOOKUP: begin
            best = 0;
            pick = -1;
            settled = 1'b0;
            for (int i = 0; i < flow_count; i++) begin
               score = entry_score(flow_entries[i], b);
               if (!settled && score >= 0) begin
                  if (score == int'(b.max_score)) begin
                     best = score;
                     pick = i;
                     settled = 1'b1;
                  end else if (score > best) begin
                     best = score;
                     pick = i;
                  end
               end
            end
            if (pick >= 0) r = answer(wftl_pkg::STATUS_OK, flow_entries[pick].id, 3'(best));
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic logic [7:0] pick_handle();
      return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
   endfunction

   function automatic logic [7:0] pick_proto();
      case ($urandom_range(0, 3))
         0: return 8'd6;
         1: return 8'd17;
         2: return 8'd1;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_port();
      case ($urandom_range(0, 9)) inside
         [0:3]: return 16'h0000;
         4: return 16'd80;
         5: return 16'd443;
         6: return 16'd53;
         7: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_addr();
      case ($urandom_range(0, 9)) inside
         [0:3]: return 32'h0000_0000;
         4: return 32'h0a00_0001;
         5: return 32'h0a00_0002;
         6: return 32'hc0a8_0001;
         7: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic wftl_pkg::req_type random_request();
      wftl_pkg::req_type   b;
      wftl_pkg::entry_type e;
      int                  roll;
      b.kind = KIND_UNUSED;
      b.handle = 8'($urandom);
      b.proto = 8'($urandom);
      b.sport = 16'($urandom);
      b.sip = $urandom;
      b.dport = 16'($urandom);
      b.dip = $urandom;
      b.max_score = 3'($urandom_range(0, 7));
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         b.kind = KIND_UNUSED;
      end else if (roll < 3 + insert_bias / 2) begin
         b.kind = wftl_pkg::KIND_INSERT;
         b.handle = pick_handle();
         b.proto = pick_proto();
         b.sport = pick_port();
         b.sip = pick_addr();
         b.dport = pick_port();
         b.dip = pick_addr();
      end else if (roll < 3 + insert_bias / 2 + (100 - insert_bias) / 4) begin
         b.kind = wftl_pkg::KIND_REMOVE;
         if (flow_count > 0 && $urandom_range(0, 9) < 7) begin
            b.handle = flow_entries[$urandom_range(0, flow_count - 1)].id;
         end else begin
            b.handle = pick_handle();
         end
      end else begin
         b.kind = wftl_pkg::KIND_LOOKUP;
         if (flow_count > 0 && $urandom_range(0, 9) < 7) begin
            e = flow_entries[$urandom_range(0, flow_count - 1)];
            b.proto = e.proto;
            b.sport = (e.sport != '0 && $urandom_range(0, 7) != 0) ? e.sport : pick_port();
            b.sip = (e.sip != '0 && $urandom_range(0, 7) != 0) ? e.sip : pick_addr();
            b.dport = (e.dport != '0 && $urandom_range(0, 7) != 0) ? e.dport : pick_port();
            b.dip = (e.dip != '0 && $urandom_range(0, 7) != 0) ? e.dip : pick_addr();
         end else begin
            b.proto = pick_proto();
            b.sport = pick_port();
            b.sip = pick_addr();
            b.dport = pick_port();
            b.dip = pick_addr();
         end
      end
      return b;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic send_beat(wftl_pkg::req_type b, bit typed, wftl_pkg::rsp_type typed_answer);
      wftl_pkg::rsp_type predicted;
      int                gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      end else begin
         gap = 0;
      end
      burst_left--;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= b;
      do @(posedge clock); while (busy);
      predicted = flow_table_apply(b);
      expected_answers.push_back(typed ? typed_answer : predicted);
      kind_tally[b.kind]++;
      status_tally[predicted.status]++;
      if (flow_count > peak_count) peak_count = flow_count;
   endtask

   always @(posedge clock) begin
      wftl_pkg::rsp_type wanted;
      if (!reset && rsp_strobe) begin
         if (expected_answers.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected, status %0d",
                                      rsp_item.status));
         end else begin
            wanted = expected_answers.pop_front();
            if (rsp_item.status != wanted.status)
               report_mismatch($sformatf("status expected %0d, got %0d",
                                         wanted.status, rsp_item.status));
            if (rsp_item.found_handle != wanted.found_handle)
               report_mismatch($sformatf("found_handle expected %02h, got %02h",
                                         wanted.found_handle, rsp_item.found_handle));
            if (rsp_item.found_score != wanted.found_score)
               report_mismatch($sformatf("found_score expected %0d, got %0d",
                                         wanted.found_score, rsp_item.found_score));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, expected_answers.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;

      directed_rows = '{
         '{make_beat(wftl_pkg::KIND_LOOKUP, 8'h00, 8'd6, 16'd0, 32'h0, 16'd0, 32'h0, 3'd4),
           1'b1, answer(wftl_pkg::STATUS_NO_MATCH, 8'h00, 3'd0)},
         '{make_beat(wftl_pkg::KIND_REMOVE, 8'h00, 8'd0, 16'd0, 32'h0, 16'd0, 32'h0, 3'd0),
           1'b1, answer(wftl_pkg::STATUS_UNKNOWN, 8'h00, 3'd0)},
         '{make_beat(KIND_UNUSED, 8'hff, 8'hff, 16'hffff, 32'hffff_ffff, 16'hffff,
                     32'hffff_ffff, 3'd7), 1'b1, answer(wftl_pkg::STATUS_NO_MATCH, 8'h00, 3'd0)},
         '{make_beat(wftl_pkg::KIND_INSERT, 8'h11, 8'd6, 16'd0, 32'h0, 16'd0, 32'h0, 3'd0),
           1'b1, answer(wftl_pkg::STATUS_OK, 8'h00, 3'd0)},
         '{make_beat(wftl_pkg::KIND_INSERT, 8'hff, 8'hff, 16'hffff, 32'hffff_ffff, 16'hffff,
                     32'hffff_ffff, 3'd7), 1'b1, answer(wftl_pkg::STATUS_OK, 8'h00, 3'd0)},
         '{make_beat(wftl_pkg::KIND_INSERT, 8'h22, 8'd6, 16'd80, 32'h0, 16'd0, 32'h0a00_0001,
                     3'd0), 1'b1, answer(wftl_pkg::STATUS_OK, 8'h00, 3'd0)},
         '{make_beat(wftl_pkg::KIND_INSERT, 8'h33, 8'd6, 16'd80, 32'hc0a8_0001, 16'd443,
                     32'h0a00_0001, 3'd0), 1'b1, answer(wftl_pkg::STATUS_OK, 8'h00, 3'd0)},
         '{make_beat(wftl_pkg::KIND_LOOKUP, 8'h00, 8'd6, 16'd80, 32'hc0a8_0001, 16'd443,
                     32'h0a00_0001, 3'd4), 1'b0, '0},
         '{make_beat(wftl_pkg::KIND_LOOKUP, 8'h00, 8'd6, 16'd80, 32'hc0a8_0001, 16'd443,
                     32'h0a00_0001, 3'd0), 1'b0, '0},
         '{make_beat(wftl_pkg::KIND_LOOKUP, 8'h00, 8'd6, 16'd80, 32'hc0a8_0001, 16'd443,
                     32'h0a00_0001, 3'd2), 1'b0, '0},
         '{make_beat(wftl_pkg::KIND_LOOKUP, 8'h00, 8'd6, 16'd80, 32'hc0a8_0001, 16'd443,
                     32'h0a00_0001, 3'd7), 1'b0, '0},
         '{make_beat(wftl_pkg::KIND_LOOKUP, 8'h00, 8'hff, 16'hffff, 32'hffff_ffff, 16'hffff,
                     32'hffff_ffff, 3'd4), 1'b0, '0},
         '{make_beat(wftl_pkg::KIND_LOOKUP, 8'h00, 8'd17, 16'd80, 32'hc0a8_0001, 16'd443,
                     32'h0a00_0001, 3'd4), 1'b1,
           answer(wftl_pkg::STATUS_NO_MATCH, 8'h00, 3'd0)},
         '{make_beat(wftl_pkg::KIND_INSERT, 8'h22, 8'd17, 16'd0, 32'h0, 16'd0, 32'h0, 3'd0),
           1'b1, answer(wftl_pkg::STATUS_OK, 8'h00, 3'd0)},
         '{make_beat(wftl_pkg::KIND_LOOKUP, 8'h00, 8'd17, 16'h1234, 32'h0, 16'd0, 32'h0,
                     3'd0), 1'b0, '0},
         '{make_beat(wftl_pkg::KIND_LOOKUP, 8'h00, 8'd17, 16'h1234, 32'h0, 16'd0, 32'h0,
                     3'd4), 1'b0, '0},
         '{make_beat(wftl_pkg::KIND_REMOVE, 8'h22, 8'd0, 16'd0, 32'h0, 16'd0, 32'h0, 3'd0),
           1'b1, answer(wftl_pkg::STATUS_OK, 8'h00, 3'd0)},
         '{make_beat(wftl_pkg::KIND_LOOKUP, 8'h00, 8'd6, 16'd80, 32'hc0a8_0001, 16'd443,
                     32'h0a00_0001, 3'd2), 1'b0, '0},
         '{make_beat(wftl_pkg::KIND_REMOVE, 8'h22, 8'd0, 16'd0, 32'h0, 16'd0, 32'h0, 3'd0),
           1'b1, answer(wftl_pkg::STATUS_OK, 8'h00, 3'd0)},
         '{make_beat(wftl_pkg::KIND_REMOVE, 8'h22, 8'd0, 16'd0, 32'h0, 16'd0, 32'h0, 3'd0),
           1'b1, answer(wftl_pkg::STATUS_UNKNOWN, 8'h00, 3'd0)},
         '{make_beat(wftl_pkg::KIND_REMOVE, 8'hff, 8'd0, 16'd0, 32'h0, 16'd0, 32'h0, 3'd0),
           1'b1, answer(wftl_pkg::STATUS_OK, 8'h00, 3'd0)},
         '{make_beat(wftl_pkg::KIND_LOOKUP, 8'h00, 8'd0, 16'd0, 32'h0, 16'd0, 32'h0, 3'd0),
           1'b0, '0},
         '{make_beat(wftl_pkg::KIND_LOOKUP, 8'h00, 8'd6, 16'd81, 32'h0, 16'd0, 32'h0a00_0001,
                     3'd4), 1'b0, '0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         send_beat(directed_rows[n].beat, directed_rows[n].typed, directed_rows[n].answer);
      end

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 128 == 0) begin
            case ($urandom_range(0, 2))
               0: insert_bias = 20;
               1: insert_bias = 50;
               default: insert_bias = 80;
            endcase
         end
         send_beat(random_request(), 1'b0, '0);
      end
      start <= 1'b0;

      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d inserts, %0d removes, %0d lookups and %0d unused kinds.",
               kind_tally[wftl_pkg::KIND_INSERT], kind_tally[wftl_pkg::KIND_REMOVE],
               kind_tally[wftl_pkg::KIND_LOOKUP], kind_tally[KIND_UNUSED]);
      $display("Answers: %0d ok, %0d no match, %0d table full, %0d unknown handle; peak %0d.",
               status_tally[wftl_pkg::STATUS_OK], status_tally[wftl_pkg::STATUS_NO_MATCH],
               status_tally[wftl_pkg::STATUS_FULL], status_tally[wftl_pkg::STATUS_UNKNOWN],
               peak_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
